// ----- rtl/i2cdiv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cdiv_pkg
// Shared widths, constants and the divisor/code table for bus clock selection.
// ----------------------------------------------------------------------------
package i2cdiv_pkg;

  localparam int CLK_W   = 28;
  localparam int BUS_W   = 23;
  localparam int CODE_W  = 6;
  localparam int DIV_W   = 12;
  localparam int ACT_W   = 24;
  localparam int BT_W    = 16;
  localparam int TBL_LEN = 51;

  localparam logic [CLK_W-1:0]  CLK_RESET    = CLK_W'(66000000);
  localparam logic [DIV_W-1:0]  MAX_DIVISOR  = DIV_W'(3840);
  localparam logic [CODE_W-1:0] MAX_CODE     = CODE_W'(6'h1f);
  localparam logic [ACT_W-1:0]  BYTE_NUM     = ACT_W'(9000000);
  localparam logic [BT_W-1:0]   BYTE_MAX     = '1;

  localparam logic [DIV_W-1:0] DIV_TBL [TBL_LEN] = '{
    12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd32,   12'd36,   12'd40,
    12'd42,   12'd44,   12'd48,   12'd52,   12'd56,   12'd60,   12'd64,   12'd72,
    12'd80,   12'd88,   12'd96,   12'd104,  12'd112,  12'd128,  12'd144,  12'd160,
    12'd192,  12'd224,  12'd240,  12'd256,  12'd288,  12'd320,  12'd384,  12'd448,
    12'd480,  12'd512,  12'd576,  12'd640,  12'd768,  12'd896,  12'd960,  12'd1024,
    12'd1152, 12'd1280, 12'd1536, 12'd1792, 12'd1920, 12'd2048, 12'd2304, 12'd2560,
    12'd3072, 12'd3840
    , 12'd3840
  };

  localparam logic [CODE_W-1:0] CODE_TBL [TBL_LEN] = '{
    6'h20, 6'h21, 6'h22, 6'h23, 6'h00, 6'h24, 6'h25, 6'h26,
    6'h03, 6'h27, 6'h28, 6'h05, 6'h29, 6'h06, 6'h2a, 6'h2b,
    6'h2c, 6'h09, 6'h2d, 6'h0a, 6'h2e, 6'h2f, 6'h0c, 6'h30,
    6'h31, 6'h32, 6'h0f, 6'h33, 6'h10, 6'h34, 6'h35, 6'h36,
    6'h13, 6'h37, 6'h14, 6'h38, 6'h39, 6'h3a, 6'h17, 6'h3b,
    6'h18, 6'h3c, 6'h3d, 6'h3e, 6'h1b, 6'h3f, 6'h1c, 6'h1d,
    6'h1e, 6'h1f
    , 6'h1f
  };

endpackage

// ----- rtl/i2c_clock_divider_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_clock_divider_select
// Picks the bus clock divider code for a requested bus frequency.
// ----------------------------------------------------------------------------
// A request is taken in every cycle (busy stays low) and its word appears on
// the out_ ports, strobed by out_valid for one cycle; the receiver cannot
// stall. The path runs through three bit-serial pipelined dividers (29, 28
// and 24 stages), the table select, actual frequency and output registers.
// Write input_clock_hz through the cfg_ channel only while no request is in
// flight.
module i2c_clock_divider_select
  import i2cdiv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [BUS_W-1:0]  in_bus_hz,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLK_W-1:0]  cfg_input_clock_hz,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_divider_code,
  output logic [DIV_W-1:0]  out_divisor,
  output logic [ACT_W-1:0]  out_actual_bus_hz,
  output logic [BT_W-1:0]   out_byte_time_us,
  output logic              out_clamped
);

  localparam int NEED_W = CLK_W + 1;
  localparam int P2_W   = CODE_W + 1;

  logic [CLK_W-1:0] clk_hz_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // hold the input clock register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      clk_hz_r <= cfg_input_clock_hz;
    end
  end

  // needed divisor: ceil(clk / bus)
  logic              accept;
  logic [NEED_W-1:0] num1;
  logic              d1_valid;
  logic [NEED_W-1:0] d1_quo;
  logic [BUS_W-1:0]  d1_den;
  logic [CLK_W-1:0]  d1_pay;

  assign accept = start && !busy;
  assign num1   = {1'b0, clk_hz_r} + NEED_W'(in_bus_hz) - NEED_W'(1);

  i2cdiv_divider #(.NW(NEED_W), .DW(BUS_W), .PW(CLK_W)) u_div_need (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_num   (num1),
    .in_den   (in_bus_hz),
    .in_pay   (clk_hz_r),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_den  (d1_den),
    .out_pay  (d1_pay)
  );

  // select the first table entry at or above the needed divisor, or the top entry when clamped
  logic              sel_clamp;
  logic [DIV_W-1:0]  sel_div;
  logic [CODE_W-1:0] sel_code;
  logic              s2_valid_r;
  logic [CLK_W-1:0]  s2_clk_r;
  logic [DIV_W-1:0]  s2_div_r;
  logic [P2_W-1:0]   s2_pay_r;

  always_comb begin
    sel_clamp = (d1_den == '0) || (d1_quo > NEED_W'(MAX_DIVISOR));
    sel_div   = MAX_DIVISOR;
    sel_code  = MAX_CODE;
    for (int i = TBL_LEN - 1; i >= 0; i--) begin
      if (DIV_TBL[i] >= d1_quo[DIV_W-1:0]) begin
        sel_div  = DIV_TBL[i];
        sel_code = CODE_TBL[i];
      end
    end
    if (sel_clamp) begin
      sel_div  = MAX_DIVISOR;
      sel_code = MAX_CODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_clk_r <= d1_pay;
    s2_div_r <= sel_div;
    s2_pay_r <= {sel_clamp, sel_code};
  end

  // actual bus frequency: clk / divisor
  logic             d2_valid;
  logic [CLK_W-1:0] d2_quo;
  logic [DIV_W-1:0] d2_den;
  logic [P2_W-1:0]  d2_pay;

  i2cdiv_divider #(.NW(CLK_W), .DW(DIV_W), .PW(P2_W)) u_div_act (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s2_valid_r),
    .in_num   (s2_clk_r),
    .in_den   (s2_div_r),
    .in_pay   (s2_pay_r),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_den  (d2_den),
    .out_pay  (d2_pay)
  );

  // register the actual frequency ahead of the byte time divider
  logic             s3_valid_r;
  logic [ACT_W-1:0] s3_act_r;
  logic [DIV_W+P2_W-1:0] s3_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_act_r <= d2_quo[ACT_W-1:0];
    s3_pay_r <= {d2_den, d2_pay};
  end

  // byte time: 9000000 / actual
  logic                  d3_valid;
  logic [ACT_W-1:0]      d3_quo;
  logic [ACT_W-1:0]      d3_den;
  logic [DIV_W+P2_W-1:0] d3_pay;
  logic [BT_W-1:0]       btime;

  i2cdiv_divider #(.NW(ACT_W), .DW(ACT_W), .PW(DIV_W + P2_W)) u_div_bt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s3_valid_r),
    .in_num   (BYTE_NUM),
    .in_den   (s3_act_r),
    .in_pay   (s3_pay_r),
    .out_valid(d3_valid),
    .out_quo  (d3_quo),
    .out_den  (d3_den),
    .out_pay  (d3_pay)
  );

  // saturate on a zero frequency or a quotient beyond 16 bits
  assign btime = ((d3_den == '0) || (d3_quo[ACT_W-1:BT_W] != '0)) ? BYTE_MAX
                                                                   : d3_quo[BT_W-1:0];

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d3_valid;
    end
  end

  // drop the finished word onto the result ports
  always_ff @(posedge clk) begin
    out_divider_code  <= d3_pay[CODE_W-1:0];
    out_clamped       <= d3_pay[CODE_W];
    out_divisor       <= d3_pay[DIV_W+P2_W-1:P2_W];
    out_actual_bus_hz <= d3_den;
    out_byte_time_us  <= btime;
  end

  assign out_valid = out_valid_r;

  // clamped words always carry the top divisor and its code
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clamped |-> out_divisor == MAX_DIVISOR && out_divider_code == MAX_CODE)
    else $error("clamped word without top divisor");

  // a zero frequency always saturates the byte time
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_actual_bus_hz == '0 |-> out_byte_time_us == BYTE_MAX)
    else $error("byte time not saturated");

  // a divisor is never below the first table entry
  a_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_divisor >= DIV_TBL[0])
    else $error("divisor below table");

  // the table select stage follows the first divider in the next cycle
  a_s2: assert property (@(posedge clk) disable iff (!rst_n)
    d1_valid |=> s2_valid_r)
    else $error("select stage lost a word");

endmodule

// ----- rtl/i2cdiv_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cdiv_divider
// Pipelined restoring divider: one quotient bit per register stage, with a
// side payload and a valid bit carried along each stage.
// ----------------------------------------------------------------------------
module i2cdiv_divider #(
  parameter int NW = 28,
  parameter int DW = 12,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [DW-1:0] out_den,
  output logic [PW-1:0] out_pay
);

  logic          vld_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] den_r [NW];
  logic [PW-1:0] pay_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [PW-1:0] pay_in;
    logic [DW:0]   shf;
    logic [DW+1:0] diff;
    logic          borrow;

    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = '0;
      assign nq_in  = in_num;
      assign den_in = in_den;
      assign pay_in = in_pay;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign nq_in  = nq_r[s-1];
      assign den_in = den_r[s-1];
      assign pay_in = pay_r[s-1];
    end

    // trial subtract of the divisor from the shifted partial remainder
    assign shf    = {rem_in, nq_in[NW-1]};
    assign diff   = {1'b0, shf} - {2'b00, den_in};
    assign borrow = diff[DW+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    // advance remainder, quotient bit and payload
    always_ff @(posedge clk) begin
      rem_r[s] <= borrow ? shf[DW-1:0] : diff[DW-1:0];
      nq_r[s]  <= {nq_in[NW-2:0], ~borrow};
      den_r[s] <= den_in;
      pay_r[s] <= pay_in;
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quo   = nq_r[NW-1];
  assign out_den   = den_r[NW-1];
  assign out_pay   = pay_r[NW-1];

endmodule
